[rtl/fpdq_pkg.sv]
`default_nettype none
package fpdq_pkg;

   // request codes
   localparam logic [1:0] REQ_INSERT      = 2'd0;
   localparam logic [1:0] REQ_POP_OLDEST  = 2'd1;
   localparam logic [1:0] REQ_POP_HIGHEST = 2'd2;

   // result status codes
   localparam logic [1:0] ST_INSERTED = 2'd0;
   localparam logic [1:0] ST_SERVED   = 2'd1;
   localparam logic [1:0] ST_EMPTY    = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   localparam int unsigned ID_W   = 32;
   localparam int unsigned PRIO_W = 32;

   // datapath operations issued by the controller
   typedef enum logic [2:0] {
      OP_NONE      = 3'd0,
      OP_CAPTURE   = 3'd1,
      OP_INSERT    = 3'd2,
      OP_TAKE_HEAD = 3'd3,
      OP_SCAN_INIT = 3'd4,
      OP_SCAN_STEP = 3'd5,
      OP_TAKE_BEST = 3'd6,
      OP_REJECT    = 3'd7
   } fpdq_op_type;

   typedef struct packed {
      fpdq_op_type op;
      logic        out_load;
   } fpdq_cmd_type;

   typedef struct packed {
      logic kind_insert;
      logic kind_pop_oldest;
      logic kind_pop_highest;
      logic empty;
      logic full;
      logic scan_done;
   } fpdq_stat_type;

endpackage
`default_nettype wire

[rtl/fpdq_ifs.sv]
`default_nettype none
interface fpdq_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [31:0] priority_value;

   modport source (output valid, output req_type, output priority_value, input ready);
   modport sink (input valid, input req_type, input priority_value, output ready);
endinterface

interface fpdq_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] served_id;

   modport source (output valid, output status, output served_id, input ready);
   modport sink (input valid, input status, input served_id, output ready);
endinterface
`default_nettype wire

[rtl/fpdq_ctrl.sv]
`default_nettype none
module fpdq_ctrl import fpdq_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  fpdq_stat_type stat,
   output fpdq_cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_DECIDE = 4'b0010,
      S_SCAN   = 4'b0100,
      S_RESP   = 4'b1000
   } fpdq_state_type;

   fpdq_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   // next state and command decode
   always_comb begin
      state_in     = state_ff;
      cmd.op       = OP_NONE;
      cmd.out_load = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_CAPTURE;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (stat.kind_insert) begin
               cmd.op   = stat.full ? OP_REJECT : OP_INSERT;
               state_in = S_RESP;
            end else if (stat.kind_pop_oldest && !stat.empty) begin
               cmd.op   = OP_TAKE_HEAD;
               state_in = S_RESP;
            end else if (stat.kind_pop_highest && !stat.empty) begin
               cmd.op   = OP_SCAN_INIT;
               state_in = S_SCAN;
            end else begin
               cmd.op   = OP_REJECT;
               state_in = S_RESP;
            end
         end
         S_SCAN: begin
            if (stat.scan_done) begin
               cmd.op   = OP_TAKE_BEST;
               state_in = S_RESP;
            end else begin
               cmd.op = OP_SCAN_STEP;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output beat valid: set on load, cleared when taken
   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // a max scan only runs over a non-empty queue
   a_scan_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> !stat.empty)
      else $error("scan running on empty queue");

   // a waiting beat is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !cmd.out_load)
      else $error("result loaded over a pending beat");

   // a waiting beat stays offered until taken
   a_beat_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> rsp_valid_ff)
      else $error("pending result beat dropped");

endmodule
`default_nettype wire

[rtl/fpdq_dp.sv]
`default_nettype none
module fpdq_dp import fpdq_pkg::*; #(
   parameter int QUEUE_DEPTH = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  fpdq_cmd_type        cmd,
   output fpdq_stat_type       stat,
   input  logic [1:0]          req_type,
   input  logic [PRIO_W-1:0]   priority_value,
   output logic [1:0]          rsp_status,
   output logic [ID_W-1:0]     rsp_served_id
);

   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   // cell row, kept in arrival order, cell 0 oldest
   logic [ID_W-1:0]   arr_ff  [QUEUE_DEPTH];
   logic [PRIO_W-1:0] prio_ff [QUEUE_DEPTH];

   logic [1:0]        kind_ff;
   logic [PRIO_W-1:0] prio_cap_ff;
   logic [CNT_W-1:0]  occ_ff, occ_in;
   logic [ID_W-1:0]   next_arr_ff, next_arr_in;
   logic [CNT_W-1:0]  scan_cnt_ff, scan_cnt_in;
   logic [IDX_W-1:0]  best_pos_ff, best_pos_in;
   logic [PRIO_W-1:0] best_prio_ff, best_prio_in;
   logic [ID_W-1:0]   best_id_ff, best_id_in;
   logic [1:0]        res_status_ff;
   logic [ID_W-1:0]   res_id_ff;
   logic [1:0]        out_status_ff;
   logic [ID_W-1:0]   out_id_ff;
   logic [CNT_W-1:0]  occ_last;
   logic [CNT_W-1:0]  best_pos_ext;

   assign occ_last     = occ_ff - CNT_W'(1);
   assign best_pos_ext = CNT_W'(best_pos_ff);

   // per cell next value: append, compact or rotate
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic [ID_W-1:0]   up_arr, arr_in;
      logic [PRIO_W-1:0] up_prio, prio_in;

      if (i < QUEUE_DEPTH - 1) begin : g_up
         assign up_arr  = arr_ff[i+1];
         assign up_prio = prio_ff[i+1];
      end else begin : g_top
         assign up_arr  = '0;
         assign up_prio = '0;
      end

      always_comb begin
         arr_in  = arr_ff[i];
         prio_in = prio_ff[i];
         case (cmd.op)
            OP_INSERT: begin
               if (occ_ff == CNT_W'(i)) begin
                  arr_in  = next_arr_ff;
                  prio_in = prio_cap_ff;
               end
            end
            OP_TAKE_HEAD: begin
               arr_in  = up_arr;
               prio_in = up_prio;
            end
            OP_TAKE_BEST: begin
               if (CNT_W'(i) >= best_pos_ext) begin
                  arr_in  = up_arr;
                  prio_in = up_prio;
               end
            end
            OP_SCAN_INIT, OP_SCAN_STEP: begin
               if (CNT_W'(i) == occ_last) begin
                  arr_in  = arr_ff[0];
                  prio_in = prio_ff[0];
               end else if (CNT_W'(i) < occ_last) begin
                  arr_in  = up_arr;
                  prio_in = up_prio;
               end
            end
            default: begin
               arr_in  = arr_ff[i];
               prio_in = prio_ff[i];
            end
         endcase
      end

      always_ff @(posedge clock) begin
         arr_ff[i]  <= arr_in;
         prio_ff[i] <= prio_in;
      end
   end

   // occupancy, arrival counter and scan tracking
   always_comb begin
      occ_in       = occ_ff;
      next_arr_in  = next_arr_ff;
      scan_cnt_in  = scan_cnt_ff;
      best_pos_in  = best_pos_ff;
      best_prio_in = best_prio_ff;
      best_id_in   = best_id_ff;
      case (cmd.op)
         OP_INSERT: begin
            occ_in      = occ_ff + CNT_W'(1);
            next_arr_in = next_arr_ff + ID_W'(1);
         end
         OP_TAKE_HEAD, OP_TAKE_BEST: begin
            occ_in = occ_last;
         end
         OP_SCAN_INIT: begin
            scan_cnt_in  = CNT_W'(1);
            best_pos_in  = '0;
            best_prio_in = prio_ff[0];
            best_id_in   = arr_ff[0];
         end
         OP_SCAN_STEP: begin
            scan_cnt_in = scan_cnt_ff + CNT_W'(1);
            // strict compare keeps the earliest arrival on ties
            if (prio_ff[0] > best_prio_ff) begin
               best_pos_in  = scan_cnt_ff[IDX_W-1:0];
               best_prio_in = prio_ff[0];
               best_id_in   = arr_ff[0];
            end
         end
         default: begin
            occ_in = occ_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff      <= '0;
         next_arr_ff <= ID_W'(1);
         scan_cnt_ff <= '0;
         best_pos_ff <= '0;
      end else begin
         occ_ff      <= occ_in;
         next_arr_ff <= next_arr_in;
         scan_cnt_ff <= scan_cnt_in;
         best_pos_ff <= best_pos_in;
      end
   end

   // request capture, result and output beat registers
   always_ff @(posedge clock) begin
      best_prio_ff <= best_prio_in;
      best_id_ff   <= best_id_in;
      if (cmd.op == OP_CAPTURE) begin
         kind_ff     <= req_type;
         prio_cap_ff <= priority_value;
      end
      case (cmd.op)
         OP_INSERT: begin
            res_status_ff <= ST_INSERTED;
            res_id_ff     <= '0;
         end
         OP_TAKE_HEAD: begin
            res_status_ff <= ST_SERVED;
            res_id_ff     <= arr_ff[0];
         end
         OP_TAKE_BEST: begin
            res_status_ff <= ST_SERVED;
            res_id_ff     <= best_id_ff;
         end
         OP_REJECT: begin
            res_status_ff <= (kind_ff == REQ_INSERT) ? ST_FULL : ST_EMPTY;
            res_id_ff     <= '0;
         end
         default: begin
            res_status_ff <= res_status_ff;
            res_id_ff     <= res_id_ff;
         end
      endcase
      if (cmd.out_load) begin
         out_status_ff <= res_status_ff;
         out_id_ff     <= res_id_ff;
      end
   end

   // status towards the controller
   assign stat.kind_insert      = (kind_ff == REQ_INSERT);
   assign stat.kind_pop_oldest  = (kind_ff == REQ_POP_OLDEST);
   assign stat.kind_pop_highest = (kind_ff == REQ_POP_HIGHEST);
   assign stat.empty            = (occ_ff == '0);
   assign stat.full             = (occ_ff == CNT_W'(QUEUE_DEPTH));
   assign stat.scan_done        = (scan_cnt_ff == occ_ff);

   assign rsp_status    = out_status_ff;
   assign rsp_served_id = out_id_ff;

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("occupancy beyond depth");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (!reset && cmd.op == OP_INSERT) |=> occ_ff == $past(occ_ff) + CNT_W'(1))
      else $error("insert did not grow occupancy");

   a_take_shrinks: assert property (@(posedge clock) disable iff (reset)
      (!reset && (cmd.op == OP_TAKE_HEAD || cmd.op == OP_TAKE_BEST))
      |=> occ_ff == $past(occ_ff) - CNT_W'(1))
      else $error("removal did not shrink occupancy");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_SCAN_STEP) |-> (scan_cnt_ff < occ_ff))
      else $error("scan index past occupancy");

endmodule
`default_nettype wire

[rtl/fifo_and_priority_dual_pop_queue_core.sv]
// channel   dir   handshake      payload
// req_ch    in    valid/ready    req_type[1:0], priority_value[31:0]
// rsp_ch    out   valid/ready    status[1:0], served_id[31:0]
//
// insert and pop-oldest: the accepted beat is captured, decided, then its result is loaded into
// the output beat; next beat accepted the cycle after the result is loaded
// pop-highest: adds a max scan before the take, one comparator reading cell 0 while
// the cell row rotates once through the max scan
// synchronous active-high reset empties the queue and sets the arrival count to 1
// a waiting result beat holds the block in its response step; one beat in flight
`default_nettype none
module fifo_and_priority_dual_pop_queue_core import fpdq_pkg::*; #(
   parameter int QUEUE_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   fpdq_req_if.sink    req_ch,
   fpdq_rsp_if.source  rsp_ch
);

   fpdq_cmd_type  cmd;
   fpdq_stat_type stat;

   // sequencer
   fpdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // cell row and result path
   fpdq_dp #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_type       (req_ch.req_type),
      .priority_value (req_ch.priority_value),
      .rsp_status     (rsp_ch.status),
      .rsp_served_id  (rsp_ch.served_id)
   );

endmodule
`default_nettype wire

[tb/sv/fpdq_queue_checker.sv]
module fpdq_queue_checker import fpdq_pkg::*; #(
   parameter int QUEUE_DEPTH = 64
) (
   input  logic clock,
   input  logic reset,
   fpdq_req_if  req_ch,
   fpdq_rsp_if  rsp_ch,
   output int   mismatch_count,
   output int   awaited_count
);

   typedef struct packed {
      logic [1:0]      status;
      logic [ID_W-1:0] served_id;
   } queue_reply_type;

   typedef struct packed {
      logic [ID_W-1:0]   arrival;
      logic [PRIO_W-1:0] prio;
   } queue_cell_type;

   // shadow of the queue, index 0 is the oldest entry
   queue_cell_type  shadow_cells[$];
   logic [ID_W-1:0] next_arrival;
   queue_reply_type pending_replies[$];

   // apply one request to the shadow queue and return the reply it should give
   function automatic queue_reply_type serve_request(input logic [1:0] kind,
                                                     input logic [PRIO_W-1:0] prio);
      queue_reply_type reply;
      queue_cell_type  fresh_cell;
      int              best;
      reply.status    = ST_EMPTY;
      reply.served_id = '0;
      case (kind)
         REQ_INSERT: begin
            if (shadow_cells.size() >= QUEUE_DEPTH) begin
               reply.status = ST_FULL;
            end else begin
               fresh_cell.arrival = next_arrival;
               fresh_cell.prio    = prio;
               shadow_cells       = {shadow_cells, fresh_cell};
               next_arrival       = next_arrival + 1'b1;
               reply.status       = ST_INSERTED;
            end
         end
         REQ_POP_OLDEST: begin
            if (shadow_cells.size() != 0) begin
               reply.served_id = shadow_cells[0].arrival;
               reply.status    = ST_SERVED;
               shadow_cells.delete(0);
            end
         end
         REQ_POP_HIGHEST: begin
            if (shadow_cells.size() != 0) begin
               // strict compare keeps the oldest entry on a tie
               best = 0;
               for (int i = 1; i < shadow_cells.size(); i++) begin
                  if (shadow_cells[i].prio > shadow_cells[best].prio) best = i;
               end
               reply.served_id = shadow_cells[best].arrival;
               reply.status    = ST_SERVED;
               shadow_cells.delete(best);
            end
         end
         default: ;  // reserved code leaves the queue alone
      endcase
      return reply;
   endfunction

   // compare result beats first, then log the request beat of the same edge
   always @(posedge clock) begin : watch
      queue_reply_type want;
      queue_reply_type fresh_reply;
      if (reset) begin
         shadow_cells.delete();
         pending_replies.delete();
         next_arrival   = 1;
         mismatch_count = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_replies.size() == 0) begin
               $error("result beat with nothing expected: status %0d, served_id %0d",
                      rsp_ch.status, rsp_ch.served_id);
               mismatch_count++;
            end else begin
               want = pending_replies.pop_front();
               if (rsp_ch.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
                  mismatch_count++;
               end
               if (rsp_ch.served_id !== want.served_id) begin
                  $error("served_id: expected %0d, actual %0d",
                         want.served_id, rsp_ch.served_id);
                  mismatch_count++;
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            fresh_reply     = serve_request(req_ch.req_type, req_ch.priority_value);
            pending_replies = {pending_replies, fresh_reply};
         end
      end
      awaited_count = pending_replies.size();
   end

endmodule

[tb/sv/fifo_and_priority_dual_pop_queue_core_tb.sv]
module fifo_and_priority_dual_pop_queue_core_tb import fpdq_pkg::*;;

   localparam int         QUEUE_DEPTH  = 64;
   localparam int         RANDOM_ITEMS = 900;
   localparam int         HOLD_CYCLES  = 400;
   localparam int         DRAIN_CYCLES = 100;
   localparam int         CYCLE_LIMIT  = 800000;
   localparam logic [1:0] REQ_RESERVED = 2'd3;

   logic clock = 1'b0;
   logic reset;
   int   mismatch_count;
   int   awaited_count;
   int   cycle_count;
   bit   calm;
   bit   hold_request;
   bit   hold_taken;

   fpdq_req_if req_ch();
   fpdq_rsp_if rsp_ch();

   fifo_and_priority_dual_pop_queue_core #(.QUEUE_DEPTH(QUEUE_DEPTH)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   fpdq_queue_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) queue_checker (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .mismatch_count (mismatch_count),
      .awaited_count  (awaited_count)
   );

   always #5 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("fifo_and_priority_dual_pop_queue_core_tb failed");
         $finish;
      end
   end

   // mostly short gaps, a few long ones, none during a calm stretch
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(99, 0);
      if (calm || roll < 45) return 0;
      if (roll < 85) return $urandom_range(3, 1);
      if (roll < 96) return $urandom_range(10, 4);
      return $urandom_range(60, 20);
   endfunction

   // wide random, narrow range for ties, or corner values
   function automatic logic [PRIO_W-1:0] pick_priority(input int mode);
      case (mode)
         0: return $urandom();
         1: return $urandom_range(3, 0);
         default: begin
            case ($urandom_range(3, 0))
               0: return '0;
               1: return '1;
               2: return 32'h8000_0000;
               default: return $urandom();
            endcase
         end
      endcase
   endfunction

   // offer one request beat and wait for it to be taken
   task automatic send_beat(input logic [1:0] kind, input logic [PRIO_W-1:0] prio);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.req_type       <= kind;
      req_ch.priority_value <= prio;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // result side: random stalls, plus one long hold-off on request
   initial begin
      hold_taken   = 1'b0;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin : take_results
         int stall;
         if (hold_request && !hold_taken) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_taken = 1'b1;
         end
         stall = pick_gap();
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   // stimulus and verdict
   initial begin : stimulus
      int          sent;
      int          epoch_len;
      int          insert_pct;
      int          prio_mode;
      bit          first_epoch;
      bit          hold_done;
      logic [1:0]  kind;

      calm                  = 1'b0;
      hold_request          = 1'b0;
      reset                 <= 1'b1;
      req_ch.valid          <= 1'b0;
      req_ch.req_type       <= REQ_INSERT;
      req_ch.priority_value <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty pops, reserved code, corner priorities, ties
      send_beat(REQ_POP_OLDEST, '1);
      send_beat(REQ_POP_HIGHEST, '0);
      send_beat(REQ_RESERVED, 32'h1234_5678);
      send_beat(REQ_INSERT, '0);
      send_beat(REQ_INSERT, '1);
      send_beat(REQ_INSERT, '1);
      send_beat(REQ_INSERT, '0);
      send_beat(REQ_INSERT, 32'h5A5A_A5A5);
      send_beat(REQ_RESERVED, '1);
      send_beat(REQ_POP_HIGHEST, '0);
      send_beat(REQ_POP_HIGHEST, '1);
      send_beat(REQ_POP_OLDEST, '0);
      send_beat(REQ_POP_HIGHEST, '0);
      send_beat(REQ_INSERT, 32'h7FFF_FFFF);
      send_beat(REQ_INSERT, 32'h8000_0000);
      send_beat(REQ_POP_HIGHEST, '0);
      send_beat(REQ_POP_OLDEST, '0);
      send_beat(REQ_POP_OLDEST, '0);
      send_beat(REQ_POP_OLDEST, '0);
      send_beat(REQ_POP_HIGHEST, '0);

      // random epochs: filling, draining or mixed, first one overfills the queue
      sent        = 0;
      first_epoch = 1'b1;
      hold_done   = 1'b0;
      while (sent < RANDOM_ITEMS) begin
         if (first_epoch) begin
            epoch_len  = QUEUE_DEPTH + 8;
            insert_pct = 100;
            prio_mode  = 0;
         end else begin
            epoch_len = $urandom_range(80, 20);
            case ($urandom_range(2, 0))
               0: insert_pct = 85;
               1: insert_pct = 15;
               default: insert_pct = 50;
            endcase
            prio_mode = $urandom_range(2, 0);
         end
         first_epoch = 1'b0;
         calm        = ($urandom_range(3, 0) == 0);
         for (int k = 0; k < epoch_len && sent < RANDOM_ITEMS; k++) begin
            // one long result hold-off while requests keep coming
            if (!hold_done && sent >= RANDOM_ITEMS / 2) begin
               hold_request = 1'b1;
               hold_done    = 1'b1;
            end
            if ($urandom_range(49, 0) == 0) begin
               send_beat(REQ_RESERVED, $urandom());
            end else begin
               if ($urandom_range(99, 0) < insert_pct) kind = REQ_INSERT;
               else if ($urandom_range(1, 0) != 0) kind = REQ_POP_HIGHEST;
               else kind = REQ_POP_OLDEST;
               send_beat(kind, (kind == REQ_INSERT) ? pick_priority(prio_mode) : $urandom());
               sent++;
            end
         end
      end
      calm         = 1'b0;
      req_ch.valid <= 1'b0;

      // wait for outstanding results, then let the block settle
      @(posedge clock);
      while (awaited_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("fifo_and_priority_dual_pop_queue_core_tb passed");
      end else begin
         $display("fifo_and_priority_dual_pop_queue_core_tb failed");
      end
      $finish;
   end

endmodule

[files.f]
rtl/fpdq_pkg.sv
rtl/fpdq_ifs.sv
rtl/fpdq_ctrl.sv
rtl/fpdq_dp.sv
rtl/fifo_and_priority_dual_pop_queue_core.sv
tb/sv/fpdq_queue_checker.sv
tb/sv/fifo_and_priority_dual_pop_queue_core_tb.sv
